// ----- design/fra_pkg.sv -----
// Shared types and constants for the analog receive parser.
// No dependencies; every other design file depends on this package.
package fra_pkg;

    // Input request kinds.
    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Framing and command bytes on the link.
    localparam logic [7:0] SYSEX_START   = 8'hF0;
    localparam logic [7:0] SYSEX_END     = 8'hF7;
    localparam logic [7:0] MAP_RESPONSE  = 8'h6A;
    localparam logic [3:0] ANALOG_OPCODE = 4'hE;

    // Result kinds.
    localparam logic [1:0] EV_SAMPLE = 2'd0;
    localparam logic [1:0] EV_MAP    = 2'd1;
    localparam logic [1:0] EV_QUERY  = 2'd2;

    localparam int CHANNEL_COUNT = 16;
    localparam int CH_W          = 4;
    localparam int VALUE_W       = 14;
    localparam int DATA_W        = 7;
    localparam int PIN_W         = 7;
    localparam int ENTRY_W       = 7;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [7:0] query_pin;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         event_res;
        logic [CH_W-1:0]    channel;
        logic [VALUE_W-1:0] sample_value;
        logic [PIN_W-1:0]   digital_pin;
        logic               found;
        logic               fresh;
        logic [ENTRY_W-1:0] map_entries;
    } out_item_t;

endpackage

// ----- design/fra_if.sv -----
// Valid/ready channel interfaces for requests into and results out of the parser.
// Depends on fra_pkg for the payload types.
interface fra_in_if;
    logic               valid;
    logic               ready;
    fra_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fra_out_if;
    logic               valid;
    logic               ready;
    fra_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/firmata_rx_analog_parser.sv -----
// A link byte that completes a sample shows its result in the cycle after acceptance; a
// query answers through ST_QUERY and the result register; a map frame answers once the
// rebuild has applied its map bytes. Throughput: one link byte per cycle while idle with the
// result register free or being emptied. A query holds off requests in ST_QUERY, which waits
// on the registered pin map read; a rebuild holds them off while it walks the sysex buffer.
// Reset is asynchronous and clears all control state and valid bits at once.
module firmata_rx_analog_parser #(
    parameter int PIN_COUNT   = 128,
    parameter int SYSEX_DEPTH = 80
) (
    input logic      clk,
    input logic      rst_n,
    fra_in_if.sink   item,
    fra_out_if.source result
);
    import fra_pkg::*;

    localparam int PIN_AW = $clog2(PIN_COUNT);
    localparam int SX_AW  = $clog2(SYSEX_DEPTH);
    localparam int SX_CW  = $clog2(SYSEX_DEPTH + 1);

    // Top-level sequencer: idle, query answer, and the two halves of one map entry.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_QUERY = 4'b0010,
        ST_LD_RD = 4'b0100,
        ST_LD_WR = 4'b1000
    } state_t;

    // Analog message phase outside sysex.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LSB  = 3'b010,
        PH_MSB  = 3'b100
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic               inside_reg, inside_next;
    logic [SX_CW-1:0]   sx_count_reg, sx_count_next;
    logic               head_map_reg, head_map_next;
    logic [CH_W-1:0]    pend_ch_reg, pend_ch_next;
    logic [7:0]         low_reg, low_next;

    // Per-channel sample values, fresh flags and the channel-to-pin map.
    logic [VALUE_W-1:0] samples_reg [CHANNEL_COUNT];
    logic [VALUE_W-1:0] samples_next [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] fresh_reg, fresh_next;
    logic [PIN_W-1:0]   poc_pin_reg [CHANNEL_COUNT];
    logic [PIN_W-1:0]   poc_pin_next [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] poc_valid_reg, poc_valid_next;

    // Pin-to-channel map: memory plus one valid bit per pin, so a rebuild
    // clears the whole map at once.
    logic [CH_W-1:0]      cop_mem [PIN_COUNT];
    logic [CH_W-1:0]      cop_rdata_reg;
    logic [PIN_COUNT-1:0] cop_valid_reg, cop_valid_next;
    logic                 cop_we;

    // Sysex frame buffer.
    logic [7:0]       sx_mem [SYSEX_DEPTH];
    logic [7:0]       sx_rdata_reg;
    logic             sx_we;
    logic             sx_re;
    logic [SX_AW-1:0] sx_raddr;

    logic [7:0]         q_pin_reg, q_pin_next;
    logic [ENTRY_W-1:0] ld_idx_reg, ld_idx_next;
    logic [ENTRY_W-1:0] ld_lim_reg, ld_lim_next;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic               in_ready;
    logic               accept;
    logic [7:0]         rx_b;
    logic [SX_CW-1:0]   sx_len;
    logic [VALUE_W-1:0] new_value;
    logic               q_in_pins;
    logic               pin_hit;
    logic               chan_hit;
    logic [CH_W-1:0]    q_ch;
    logic [PIN_W-1:0]   q_dig;

    // A request is taken only in idle, and only when the result register is
    // free or is being emptied in the same cycle.
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || result.ready);
    assign accept   = item.valid && in_ready;
    assign rx_b     = item.data.rx_byte;

    assign item.ready   = in_ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Map length is the frame length less the response command byte.
    assign sx_len    = sx_count_reg - SX_CW'(1);
    // The low byte's top bit overlaps the lowest data bit of the high byte.
    assign new_value = VALUE_W'(low_reg) | {rx_b[DATA_W-1:0], 7'b0};

    // Query resolution, first as a pin number, then as a channel number.
    assign q_in_pins = (q_pin_reg < 8'(PIN_COUNT));
    assign pin_hit   = q_in_pins && cop_valid_reg[q_pin_reg[PIN_AW-1:0]];
    assign chan_hit  = (q_pin_reg[7:CH_W] == '0) && poc_valid_reg[q_pin_reg[CH_W-1:0]];
    assign q_ch      = pin_hit ? cop_rdata_reg : q_pin_reg[CH_W-1:0];
    assign q_dig     = pin_hit ? q_pin_reg[PIN_W-1:0] : poc_pin_reg[q_pin_reg[CH_W-1:0]];

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        inside_next    = inside_reg;
        sx_count_next  = sx_count_reg;
        head_map_next  = head_map_reg;
        pend_ch_next   = pend_ch_reg;
        low_next       = low_reg;
        samples_next   = samples_reg;
        fresh_next     = fresh_reg;
        poc_pin_next   = poc_pin_reg;
        poc_valid_next = poc_valid_reg;
        cop_valid_next = cop_valid_reg;
        q_pin_next     = q_pin_reg;
        ld_idx_next    = ld_idx_reg;
        ld_lim_next    = ld_lim_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;
        sx_we          = 1'b0;
        sx_re          = 1'b0;
        sx_raddr       = SX_AW'(ld_idx_reg + ENTRY_W'(1));
        cop_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.data.mode == MODE_QUERY)
                    begin
                        q_pin_next = item.data.query_pin;
                        state_next = ST_QUERY;
                    end
                    else if (inside_reg)
                    begin
                        if (rx_b == SYSEX_END)
                        begin
                            inside_next   = 1'b0;
                            sx_count_next = '0;
                            if ((sx_count_reg != '0) && head_map_reg)
                            begin
                                // Both maps are cleared before the rebuild starts.
                                poc_valid_next = '0;
                                cop_valid_next = '0;
                                ld_idx_next    = '0;
                                if (int'(sx_len) > PIN_COUNT)
                                    ld_lim_next = ENTRY_W'(PIN_COUNT);
                                else
                                    ld_lim_next = ENTRY_W'(sx_len);
                                state_next = ST_LD_RD;
                            end
                        end
                        else if (sx_count_reg < SX_CW'(SYSEX_DEPTH))
                        begin
                            sx_we         = 1'b1;
                            sx_count_next = sx_count_reg + SX_CW'(1);
                            if (sx_count_reg == '0)
                                head_map_next = (rx_b == MAP_RESPONSE);
                        end
                    end
                    else if (rx_b == SYSEX_START)
                    begin
                        inside_next   = 1'b1;
                        sx_count_next = '0;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_LSB:
                            begin
                                low_next   = rx_b;
                                phase_next = PH_MSB;
                            end
                            PH_MSB:
                            begin
                                samples_next[pend_ch_reg] = new_value;
                                fresh_next[pend_ch_reg]   = 1'b1;
                                phase_next                = PH_IDLE;
                                out_valid_next            = 1'b1;
                                out_data_next             = '0;
                                out_data_next.event_res    = EV_SAMPLE;
                                out_data_next.channel      = pend_ch_reg;
                                out_data_next.sample_value = new_value;
                            end
                            PH_IDLE:
                            begin
                                if (rx_b[7:4] == ANALOG_OPCODE)
                                begin
                                    pend_ch_next = rx_b[CH_W-1:0];
                                    phase_next   = PH_LSB;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            end

            ST_QUERY:
            begin
                out_valid_next          = 1'b1;
                out_data_next           = '0;
                out_data_next.event_res = EV_QUERY;
                if (pin_hit || chan_hit)
                begin
                    out_data_next.channel      = q_ch;
                    out_data_next.sample_value = samples_reg[q_ch];
                    out_data_next.digital_pin  = q_dig;
                    out_data_next.found        = 1'b1;
                    out_data_next.fresh        = fresh_reg[q_ch];
                    fresh_next[q_ch]           = 1'b0;
                end
                state_next = ST_IDLE;
            end

            ST_LD_RD:
            begin
                if (ld_idx_reg == ld_lim_reg)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next             = '0;
                    out_data_next.event_res   = EV_MAP;
                    out_data_next.map_entries = ld_lim_reg;
                    state_next                = ST_IDLE;
                end
                else
                begin
                    sx_re      = 1'b1;
                    state_next = ST_LD_WR;
                end
            end

            ST_LD_WR:
            begin
                // Channel bytes of sixteen or more leave the pin unmapped.
                if (sx_rdata_reg[7:CH_W] == '0)
                begin
                    cop_we = 1'b1;
                    cop_valid_next[ld_idx_reg[PIN_AW-1:0]] = 1'b1;
                    poc_pin_next[sx_rdata_reg[CH_W-1:0]]   = PIN_W'(ld_idx_reg);
                    poc_valid_next[sx_rdata_reg[CH_W-1:0]] = 1'b1;
                end
                ld_idx_next = ld_idx_reg + ENTRY_W'(1);
                state_next  = ST_LD_RD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            inside_reg    <= 1'b0;
            sx_count_reg  <= '0;
            head_map_reg  <= 1'b0;
            pend_ch_reg   <= '0;
            low_reg       <= '0;
            fresh_reg     <= '0;
            poc_valid_reg <= '0;
            cop_valid_reg <= '0;
            ld_idx_reg    <= '0;
            ld_lim_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                samples_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            inside_reg    <= inside_next;
            sx_count_reg  <= sx_count_next;
            head_map_reg  <= head_map_next;
            pend_ch_reg   <= pend_ch_next;
            low_reg       <= low_next;
            fresh_reg     <= fresh_next;
            poc_valid_reg <= poc_valid_next;
            cop_valid_reg <= cop_valid_next;
            ld_idx_reg    <= ld_idx_next;
            ld_lim_reg    <= ld_lim_next;
            out_valid_reg <= out_valid_next;
            samples_reg   <= samples_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        q_pin_reg    <= q_pin_next;
        out_data_reg <= out_data_next;
        poc_pin_reg  <= poc_pin_next;
    end

    // Sysex buffer: written at the fill count, read during a map rebuild.
    always_ff @(posedge clk)
    begin
        if (sx_we)
            sx_mem[sx_count_reg[SX_AW-1:0]] <= rx_b;
        if (sx_re)
            sx_rdata_reg <= sx_mem[sx_raddr];
    end

    // Pin map memory: written during a rebuild, read when a query is taken.
    always_ff @(posedge clk)
    begin
        if (cop_we)
            cop_mem[ld_idx_reg[PIN_AW-1:0]] <= sx_rdata_reg[CH_W-1:0];
        if (accept && (item.data.mode == MODE_QUERY))
            cop_rdata_reg <= cop_mem[item.data.query_pin[PIN_AW-1:0]];
    end

endmodule

// ----- design/fra_checker.sv -----
// Port-level checks for the analog receive parser, bound to the top level.
// Depends on fra_pkg for the result type and event codes.
module fra_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input fra_pkg::out_item_t out_data
);
    import fra_pkg::*;

    // A pending result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result payload changed while stalled");

    // A request is never taken while an untaken result blocks the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("request taken with a full result register");

    // Fields that do not belong to the result kind read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.event_res != EV_QUERY) |->
            !out_data.found && !out_data.fresh && (out_data.digital_pin == '0))
        else $error("query fields set on a non-query result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.event_res == EV_QUERY) && !out_data.found |->
            (out_data.channel == '0) && (out_data.sample_value == '0) &&
            !out_data.fresh && (out_data.map_entries == '0))
        else $error("unresolved query carries data");

endmodule

bind firmata_rx_analog_parser fra_checker u_fra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
